### sv/sepm_pkg.sv
// Shared types and constants for the SHA-256 entropy pool mixer.
// Holds round constants, initial hash values, opcodes and controller command types.
package sepm_pkg;

    localparam int DIGEST_BYTES = 32;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic KIND_SALTED = 1'b0;
    localparam logic KIND_POOL   = 1'b1;

    // Message source for one compression pass
    typedef enum logic [2:0] {
        MSG_CHUNK  = 3'b001,   // chunk plus padding (32-byte message)
        MSG_V1POOL = 3'b010,   // v1 || pool, first block of a 64-byte message
        MSG_V1V2   = 3'b100    // v1 || v2, first block of a 64-byte message
    } t_msg_sel;

    // Digest destination after a pass
    typedef enum logic [2:0] {
        DST_V1   = 3'b001,
        DST_V2   = 3'b010,
        DST_POOL = 3'b100
    } t_dst_sel;

    typedef struct packed {
        logic     start;      // load working vars and schedule
        logic     use_prev;   // chain from current hash instead of IV
        logic     pad_block;  // schedule is the fixed padding block of 512 bits
        t_msg_sel msg;
        logic     finish;     // add working vars into hash
        t_dst_sel dst;        // where finished hash goes
        logic     store_dst;
    } t_cmd;

    typedef struct packed {
        logic round_done;     // round 63 executes in this cycle
    } t_status;

    function automatic logic [31:0] kround(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    localparam logic [255:0] HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage

### sv/sepm_datapath.sv
// Datapath of the entropy pool mixer: chunk store, pool, digests and one
// SHA-256 round unit with a 16-word rolling message schedule. Uses sepm_pkg.
module sepm_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sepm_pkg::t_cmd  i_cmd,
    input  logic            i_round_en,
    input  logic            i_chunk_wr,
    input  logic [1:0]      i_chunk_idx,
    input  logic [63:0]     i_chunk_word,
    input  logic [1:0]      i_out_idx,
    input  logic            i_out_pool,
    output logic [63:0]     o_out_word,
    output sepm_pkg::t_status o_status
);

    logic [63:0]  r_chunk [4];
    logic [255:0] r_pool, r_v1, r_v2, r_hash;
    logic [31:0]  r_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [5:0]   r_round;

    logic [255:0] chunk_bytes, pool_bytes;
    logic [511:0] blk;
    logic [255:0] hash_in;
    logic [31:0]  t1, t2, s0, s1, w_new;
    logic [255:0] hash_sum;

    // Rearrange a little-endian word group into SHA byte order (byte 0 first)
    function automatic logic [255:0] to_msg(input logic [255:0] v);
        logic [255:0] r;
        for (int k = 0; k < sepm_pkg::DIGEST_BYTES; k++) r[255-8*k -: 8] = v[8*k +: 8];
        return r;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign chunk_bytes = to_msg({r_chunk[3], r_chunk[2], r_chunk[1], r_chunk[0]});
    assign pool_bytes  = to_msg(r_pool);

    // Select the message block for this pass
    always_comb begin
        blk = '0;
        if (i_cmd.pad_block) begin
            blk = {1'b1, 501'b0, 10'd512};
        end else begin
            unique case (i_cmd.msg)
                sepm_pkg::MSG_CHUNK:  blk = {chunk_bytes, 1'b1, 245'b0, 10'd256};
                sepm_pkg::MSG_V1POOL: blk = {r_v1, pool_bytes};
                sepm_pkg::MSG_V1V2:   blk = {r_v1, r_v2};
                default:              blk = '0;
            endcase
        end
    end

    assign hash_in = i_cmd.use_prev ? r_hash : sepm_pkg::HASH_INIT;

    // One round
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        t1 = r_h + (rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25))
           + ((r_e & r_f) ^ (~r_e & r_g)) + sepm_pkg::kround(r_round) + r_w[0];
        t2 = (rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22))
           + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    end

    assign hash_sum = {r_hash[255:224] + r_a, r_hash[223:192] + r_b,
                       r_hash[191:160] + r_c, r_hash[159:128] + r_d,
                       r_hash[127:96] + r_e,  r_hash[95:64] + r_f,
                       r_hash[63:32] + r_g,   r_hash[31:0] + r_h};

    assign o_status.round_done = i_round_en && (r_round == 6'd63);

    // Chunk store
    always_ff @(posedge i_clk) begin
        if (i_chunk_wr) begin
            r_chunk[i_chunk_idx] <= i_chunk_word;
        end
    end

    // Round counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
        end else if (i_cmd.start) begin
            r_round <= '0;
        end else if (i_round_en) begin
            r_round <= r_round + 6'd1;
        end
    end

    // Working variables, schedule, hash
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hash <= hash_in;
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= hash_in;
            for (int i = 0; i < 16; i++) r_w[i] <= blk[511-32*i -: 32];
        end else if (i_round_en) begin
            {r_a, r_b, r_c, r_d} <= {t1 + t2, r_a, r_b, r_c};
            {r_e, r_f, r_g, r_h} <= {r_d + t1, r_e, r_f, r_g};
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end else if (i_cmd.finish) begin
            r_hash <= hash_sum;
        end
    end

    // Digest destinations; pool cleared by reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_dst && i_cmd.dst == sepm_pkg::DST_V1) r_v1 <= r_hash;
        if (i_cmd.store_dst && i_cmd.dst == sepm_pkg::DST_V2) r_v2 <= r_hash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= '0;
        end else if (i_cmd.store_dst && i_cmd.dst == sepm_pkg::DST_POOL) begin
            r_pool <= to_msg(r_hash);
        end
    end

    // Output word: pool or chunk XOR v2 (v2 in little-endian word order)
    logic [255:0] v2_words;
    assign v2_words = to_msg(r_v2);
    assign o_out_word = i_out_pool ? r_pool[64*i_out_idx +: 64]
                                   : (r_chunk[i_out_idx] ^ v2_words[64*i_out_idx +: 64]);

endmodule

### sv/sepm_ctrl.sv
// Controller of the entropy pool mixer: sequences five compressions and
// the four-beat output run. Uses sepm_pkg command and status types.
module sepm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_op,
    input  logic              i_final,
    output logic              o_in_ready,
    output logic              o_chunk_wr,
    output logic [1:0]        o_chunk_idx,
    output sepm_pkg::t_cmd    o_cmd,
    output logic              o_round_en,
    input  sepm_pkg::t_status i_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_out_idx,
    output logic              o_out_pool,
    output logic              o_out_final
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_ROUND = 6'b000100,
        S_FIN   = 6'b001000,
        S_STORE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_wcnt, n_wcnt;
    logic [2:0] r_pass, n_pass;   // 0..4: v1, v2 blk0, v2 pad, pool blk0, pool pad
    logic [1:0] r_oidx, n_oidx;
    logic       r_pool_rd, n_pool_rd, r_fin, n_fin;
    logic       acc, oacc;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc  = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign oacc = o_out_valid && i_out_ready;
    assign o_chunk_wr  = acc && (i_op == sepm_pkg::OP_FEED);
    assign o_chunk_idx = r_wcnt;
    assign o_round_en  = (r_state == S_ROUND);
    assign o_out_idx   = r_oidx;
    assign o_out_pool  = r_pool_rd;
    assign o_out_final = r_fin && (r_oidx == 2'd3);

    // Decode command for current pass
    always_comb begin
        o_cmd = '0;
        o_cmd.msg = sepm_pkg::MSG_CHUNK;
        o_cmd.dst = sepm_pkg::DST_V1;
        unique case (r_pass)
            3'd0: o_cmd.msg = sepm_pkg::MSG_CHUNK;
            3'd1: o_cmd.msg = sepm_pkg::MSG_V1POOL;
            3'd2: o_cmd.pad_block = 1'b1;
            3'd3: o_cmd.msg = sepm_pkg::MSG_V1V2;
            default: o_cmd.pad_block = 1'b1;
        endcase
        o_cmd.use_prev = (r_pass == 3'd2) || (r_pass == 3'd4);
        o_cmd.start    = (r_state == S_START);
        o_cmd.finish   = (r_state == S_FIN);
        o_cmd.store_dst = (r_state == S_STORE) && (r_pass != 3'd1) && (r_pass != 3'd3);
        if (r_pass == 3'd2) o_cmd.dst = sepm_pkg::DST_V2;
        else if (r_pass == 3'd4) o_cmd.dst = sepm_pkg::DST_POOL;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_wcnt = r_wcnt;
        n_pass = r_pass;
        n_oidx = r_oidx;
        n_pool_rd = r_pool_rd;
        n_fin = r_fin;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_oidx = '0;
                    if (i_op == sepm_pkg::OP_READ) begin
                        n_pool_rd = 1'b1;
                        n_fin = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_wcnt = r_wcnt + 2'd1;
                        if (r_wcnt == 2'd3) begin
                            n_pool_rd = 1'b0;
                            n_fin = i_final;
                            n_pass = '0;
                            n_state = S_START;
                        end
                    end
                end
            end
            S_START: n_state = S_ROUND;
            S_ROUND: if (i_status.round_done) n_state = S_FIN;
            S_FIN:   n_state = S_STORE;
            S_STORE: begin
                if (r_pass == 3'd4) begin
                    n_state = S_OUT;
                end else begin
                    n_pass = r_pass + 3'd1;
                    n_state = S_START;
                end
            end
            S_OUT: begin
                if (oacc) begin
                    n_oidx = r_oidx + 2'd1;
                    if (r_oidx == 2'd3) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wcnt <= '0;
            r_pass <= '0;
            r_oidx <= '0;
            r_pool_rd <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wcnt <= n_wcnt;
            r_pass <= n_pass;
            r_oidx <= n_oidx;
            r_pool_rd <= n_pool_rd;
            r_fin <= n_fin;
        end
    end

endmodule

### sv/sha256_entropy_pool_mixer.sv
// SHA-256 entropy pool mixer, top level.
// Channels: s_axis accepts one 64-bit word per beat. tuser = operation,
// tlast = final_chunk. A feed beat stores the word; the fourth feed beat
// of a chunk starts the mixing. A read beat (operation 1) returns the pool.
// m_axis returns runs of four beats: tdata = data_word, tuser (low bit up) =
// word_position[1:0], result_kind, request_end; tlast = last_of_run.
// Mixing: the fourth feed word is followed by five SHA-256 compressions on
// one shared round unit, each one load, 64 rounds, add and store, after which
// the first output beat is presented. A read yields its first beat the next
// cycle. Feed words 1 to 3 are only stored, and the input stays open for the
// next word.
// The input is held off (s_axis_tready low) from acceptance of a read or of the
// fourth feed word until the last beat of a run is taken; a stalled receiver simply holds the current beat.
// Reset clears the pool to zero, the word count and the controller.
module sha256_entropy_pool_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // random_word[63:0]
    input  logic [0:0]  s_axis_tuser,   // operation
    input  logic        s_axis_tlast,   // final_chunk
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // data_word[63:0]
    output logic [3:0]  m_axis_tuser,   // word_position[1:0], result_kind, request_end
    output logic        m_axis_tlast
);

    sepm_pkg::t_cmd    cmd;
    sepm_pkg::t_status status;
    logic       round_en, chunk_wr, out_pool, out_final;
    logic [1:0] chunk_idx, out_idx;

    sepm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_op(s_axis_tuser[0]), .i_final(s_axis_tlast),
        .o_in_ready(s_axis_tready), .o_chunk_wr(chunk_wr), .o_chunk_idx(chunk_idx),
        .o_cmd(cmd), .o_round_en(round_en), .i_status(status),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_idx(out_idx), .o_out_pool(out_pool), .o_out_final(out_final)
    );

    sepm_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_round_en(round_en),
        .i_chunk_wr(chunk_wr), .i_chunk_idx(chunk_idx), .i_chunk_word(s_axis_tdata),
        .i_out_idx(out_idx), .i_out_pool(out_pool), .o_out_word(m_axis_tdata),
        .o_status(status)
    );

    assign m_axis_tuser = {out_final, out_pool, out_idx};
    assign m_axis_tlast = (out_idx == 2'd3);

    // Input and output never active together
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input and output both open");

    // A run ends on its last beat and then reopens the input
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not reopened after run");

    // Request end only on the last salted beat
    a_req_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |-> (m_axis_tlast && !m_axis_tuser[2]))
        else $error("request end misplaced");

endmodule

### tb/tb.sv
// Testbench for sha256_entropy_pool_mixer: feeds chunks and pool reads over the stream
// input, predicts the salted words and pool contents with its own SHA-256, checks each beat.
// Depends on sepm_pkg and the mixer RTL.
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        op;
        logic [63:0] word;
        logic        fin;
    } t_feed;

    typedef struct packed {
        logic [63:0] data;
        logic [1:0]  pos;
        logic        kind;
        logic        last;
        logic        req_end;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;    // random_word[63:0]
    logic [0:0]  s_axis_tuser;    // operation
    logic        s_axis_tlast;    // final_chunk
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;    // data_word[63:0]
    logic [3:0]  m_axis_tuser;    // word_position[1:0], result_kind, request_end
    logic        m_axis_tlast;

    sha256_entropy_pool_mixer dut (.*);

    t_feed       pending_feeds[$];
    t_beat       expected_beats[$];
    logic [63:0] pool_model[4];
    logic [63:0] chunk_model[4];
    int          word_count;
    int          error_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    // SHA-256 over 32-byte values held as four little-endian 64-bit words
    function automatic logic [7:0] byte_of(input logic [63:0] w[4], input int k);
        return w[k / 8][8 * (k % 8) +: 8];
    endfunction

    function automatic void compress_block(ref logic [31:0] h[8], input logic [7:0] blk[64]);
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = {w[i-15][6:0], w[i-15][31:7]} ^ {w[i-15][17:0], w[i-15][31:18]} ^ (w[i-15] >> 3);
            s1 = {w[i-2][16:0], w[i-2][31:17]} ^ {w[i-2][18:0], w[i-2][31:19]} ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = hh + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
                 + ((e & f) ^ (~e & g)) + sepm_pkg::kround(i[5:0]) + w[i];
            t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
                 + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    endfunction

    // Hash of x (32 bytes), or of x || y (64 bytes) when two_part is set
    function automatic void digest(input logic [63:0] x[4], input logic [63:0] y[4],
                                   input bit two_part, output logic [63:0] res[4]);
        logic [7:0]  blk[64];
        logic [31:0] h[8];
        logic [7:0]  hb[32];
        for (int i = 0; i < 8; i++) h[i] = sepm_pkg::HASH_INIT[255 - 32*i -: 32];
        for (int k = 0; k < 64; k++) blk[k] = 8'h00;
        for (int k = 0; k < 32; k++) blk[k] = byte_of(x, k);
        if (two_part) begin
            for (int k = 0; k < 32; k++) blk[32 + k] = byte_of(y, k);
            compress_block(h, blk);
            for (int k = 0; k < 64; k++) blk[k] = 8'h00;
            blk[0] = 8'h80;
            blk[62] = 8'h02;   // 512 bits
        end else begin
            blk[32] = 8'h80;
            blk[62] = 8'h01;   // 256 bits
        end
        compress_block(h, blk);
        for (int i = 0; i < 8; i++) {hb[4*i], hb[4*i+1], hb[4*i+2], hb[4*i+3]} = h[i];
        for (int k = 0; k < 4; k++)
            for (int j = 0; j < 8; j++) res[k][8*j +: 8] = hb[8*k + j];
    endfunction

    // Advance the mixer state by one accepted beat and queue the beats it yields
    function automatic void predict_mix(input t_feed it);
        logic [63:0] v1[4], v2[4], v3[4];
        t_beat b;
        if (it.op == sepm_pkg::OP_READ) begin
            for (int i = 0; i < 4; i++) begin
                b = '{pool_model[i], i[1:0], sepm_pkg::KIND_POOL, i == 3, 1'b0};
                expected_beats.push_back(b);
            end
            return;
        end
        chunk_model[word_count] = it.word;
        if (word_count != 3) begin
            word_count++;
            return;
        end
        word_count = 0;
        digest(chunk_model, chunk_model, 0, v1);
        digest(v1, pool_model, 1, v2);
        digest(v1, v2, 1, v3);
        pool_model = v3;
        for (int i = 0; i < 4; i++) begin
            b = '{chunk_model[i] ^ v2[i], i[1:0], sepm_pkg::KIND_SALTED, i == 3,
                  i == 3 && it.fin};
            expected_beats.push_back(b);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive input beats from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) predict_mix(pending_feeds.pop_front());
            if (pending_feeds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_feeds[0].word;
                s_axis_tuser  <= pending_feeds[0].op;
                s_axis_tlast  <= pending_feeds[0].fin;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Check output beats, stall the receiver at random, watch for a hang
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata, 64'h0);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_axis_tdata !== want.data)
                        report_mismatch("data_word", m_axis_tdata, want.data);
                    if (m_axis_tuser[1:0] !== want.pos)
                        report_mismatch("word_position", 64'(m_axis_tuser[1:0]),
                                        64'(want.pos));
                    if (m_axis_tuser[2] !== want.kind)
                        report_mismatch("result_kind", 64'(m_axis_tuser[2]), 64'(want.kind));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_run", 64'(m_axis_tlast), 64'(want.last));
                    if (m_axis_tuser[3] !== want.req_end)
                        report_mismatch("request_end", 64'(m_axis_tuser[3]),
                                        64'(want.req_end));
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
        m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end

    // Queue one chunk of four feed words; read_inside slips a read in before the third word
    task automatic add_chunk(input bit fin_last, input bit read_inside, input bit noisy_fin);
        for (int i = 0; i < 4; i++) begin
            if (read_inside && i == 2)
                pending_feeds.push_back('{sepm_pkg::OP_READ, {$urandom, $urandom},
                                         1'($urandom)});
            pending_feeds.push_back('{sepm_pkg::OP_FEED, {$urandom, $urandom},
                                     i == 3 ? fin_last : (noisy_fin & 1'($urandom))});
        end
    endtask

    task automatic wait_drained();
        while (pending_feeds.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        word_count    = 0;
        error_count   = 0;
        idle_cycles   = 0;
        send_idle_pct = 6;
        recv_idle_pct = 84;
        for (int i = 0; i < 4; i++) pool_model[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: read of the cleared pool, extreme words, final flag on early and last
        // words, read in the middle of a chunk, readout with the final flag set
        pending_feeds.push_back('{sepm_pkg::OP_READ, 64'h0, 1'b0});
        for (int i = 0; i < 4; i++)
            pending_feeds.push_back('{sepm_pkg::OP_FEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
        for (int i = 0; i < 4; i++)
            pending_feeds.push_back('{sepm_pkg::OP_FEED, 64'h0, 1'b0});
        pending_feeds.push_back('{sepm_pkg::OP_READ, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
        add_chunk(1'b1, 1'b1, 1'b1);
        add_chunk(1'b0, 1'b0, 1'b1);
        pending_feeds.push_back('{sepm_pkg::OP_READ, 64'h0, 1'b1});
        wait_drained();

        // Random: mostly whole chunks with random content, some reads scattered in
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 6 : (phase == 1 ? 84 : 0);
            recv_idle_pct = phase == 0 ? 84 : (phase == 1 ? 6 : 0);
            n = 0;
            while (n < 33) begin
                if ($urandom_range(5) == 0) begin
                    pending_feeds.push_back('{sepm_pkg::OP_READ, {$urandom, $urandom},
                                             1'($urandom)});
                    n++;
                end else begin
                    add_chunk(1'($urandom), $urandom_range(3) == 0, 1'b1);
                    n += 4;
                end
            end
            wait_drained();
        end

        repeat (400) @(posedge i_clk);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
